// ===== rtl/core/bbc_pkg.sv =====
// Shared types, codes and widths for the bracket balance checker.
// Depends on nothing; every module of the block imports it.
package bbc_pkg;

    // Field widths fixed by the item format
    localparam int ACTION_WIDTH = 2;
    localparam int POS_WIDTH    = 10;
    localparam int SYM_WIDTH    = 2;
    localparam int LENGTH_WIDTH = 11;

    // Default store depth
    localparam int MAX_LEN_DEFAULT = 1024;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Action codes on the input beat
    localparam logic [ACTION_WIDTH-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_FLIP  = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_CHECK = 2'd2;

    // Symbol codes
    localparam logic [SYM_WIDTH-1:0] SYM_OTHER = 2'd0;
    localparam logic [SYM_WIDTH-1:0] SYM_OPEN  = 2'd1;
    localparam logic [SYM_WIDTH-1:0] SYM_CLOSE = 2'd2;

    // Input beat
    typedef struct packed {
        logic [ACTION_WIDTH-1:0] action;
        logic [POS_WIDTH-1:0]    position;
        logic [SYM_WIDTH-1:0]    symbol_code;
    } in_t;

    // Result beat
    typedef struct packed {
        logic balanced;
        logic bad_position;
    } out_t;

    // Classified operations for the back end
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FLIP,
        OP_CHECK
    } op_t;

    // Queued command
    typedef struct packed {
        op_t                  op;
        logic                 bad;
        logic [POS_WIDTH-1:0] position;
        logic [SYM_WIDTH-1:0] symbol;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_FLIP,
        BK_WALK
    } back_state_t;

endpackage

// ===== rtl/core/bbc_front.sv =====
// Front end: holds the length register, accepts input beats and classifies them
// into queued commands. Depends on bbc_pkg.
module bbc_front #(
    parameter int MAX_LEN = bbc_pkg::MAX_LEN_DEFAULT,
    parameter int LEN_W   = bbc_pkg::LENGTH_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bbc_pkg::LENGTH_WIDTH-1:0]  cfg_wr_data,
    input  logic                              start,
    input  bbc_pkg::in_t                      item,
    input  logic                              q_full,
    output logic                              push,
    output bbc_pkg::cmd_t                     push_cmd,
    output logic [LEN_W-1:0]                  used_len
);
    import bbc_pkg::*;

    logic [LENGTH_WIDTH-1:0] length_reg;
    logic [LENGTH_WIDTH-1:0] length_next;
    logic [LEN_W-1:0]        len_ext;
    logic [LEN_W-1:0]        pos_ext;
    logic                    in_range;
    logic                    accept;

    // Hold the configured length
    always_comb
    begin
        length_next = cfg_wr_en ? cfg_wr_data : length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else
        begin
            length_reg <= length_next;
        end
    end

    // Saturate the length to the store depth
    assign len_ext  = LEN_W'(length_reg);
    assign used_len = (len_ext > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_ext;

    assign pos_ext  = LEN_W'(item.position);
    assign in_range = pos_ext < used_len;
    assign accept   = start && !q_full;

    // Classify the beat; unknown actions are dropped
    always_comb
    begin
        push              = 1'b0;
        push_cmd.op       = OP_CHECK;
        push_cmd.bad      = 1'b0;
        push_cmd.position = item.position;
        push_cmd.symbol   = (item.symbol_code == SYM_OPEN || item.symbol_code == SYM_CLOSE)
                            ? item.symbol_code : SYM_OTHER;
        case (item.action)
            ACT_LOAD:
            begin
                push         = accept;
                push_cmd.op  = in_range ? OP_LOAD : OP_CHECK;
                push_cmd.bad = !in_range;
            end
            ACT_FLIP:
            begin
                push         = accept;
                push_cmd.op  = in_range ? OP_FLIP : OP_CHECK;
                push_cmd.bad = !in_range;
            end
            ACT_CHECK:
            begin
                push = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/bbc_cmd_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on bbc_pkg.
module bbc_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bbc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output bbc_pkg::cmd_t cmd
);
    import bbc_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign cmd     = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/bbc_back.sv =====
// Back end: owns the symbol memory, carries out loads and flips, and walks the
// string one symbol per cycle to compute the balance result. Depends on bbc_pkg.
module bbc_back #(
    parameter int MAX_LEN = bbc_pkg::MAX_LEN_DEFAULT,
    parameter int LEN_W   = bbc_pkg::LENGTH_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LEN_W-1:0]  used_len,
    input  logic              q_valid,
    input  bbc_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output logic              done,
    output bbc_pkg::out_t     result
);
    import bbc_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEN);

    back_state_t          state_reg;
    back_state_t          state_next;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    logic [LEN_W-1:0]     rd_addr_reg;
    logic [LEN_W-1:0]     rd_addr_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [LEN_W-1:0]     depth_reg;
    logic [LEN_W-1:0]     depth_next;
    logic                 fail_reg;
    logic                 fail_next;
    logic                 done_reg;
    logic                 done_next;
    out_t                 result_reg;
    out_t                 result_next;

    logic [SYM_WIDTH-1:0] sym_mem [MAX_LEN];
    logic [SYM_WIDTH-1:0] rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [SYM_WIDTH-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [ADDR_W-1:0]    mem_rd_addr;

    logic [ADDR_W-1:0]    pos_addr;
    logic                 walk_end;

    assign pos_addr = ADDR_W'(LEN_W'(cmd_reg.position));
    assign walk_end = !pend_reg && (rd_addr_reg >= used_len);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                case (cmd_reg.op)
                    OP_LOAD:  state_next = BK_IDLE;
                    OP_FLIP:  state_next = BK_FLIP;
                    OP_CHECK: state_next = BK_WALK;
                    default:  state_next = BK_IDLE;
                endcase
            end
            BK_FLIP:
            begin
                state_next = BK_WALK;
            end
            BK_WALK:
            begin
                if (walk_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs, memory control and walk datapath
    always_comb
    begin
        q_pop        = 1'b0;
        cmd_next     = cmd_reg;
        mem_we       = 1'b0;
        mem_wr_addr  = pos_addr;
        mem_wr_data  = cmd_reg.symbol;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = pos_addr;
        rd_addr_next = rd_addr_reg;
        pend_next    = 1'b0;
        depth_next   = depth_reg;
        fail_next    = fail_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop    = q_valid;
                cmd_next = q_cmd;
            end
            BK_EXEC:
            begin
                case (cmd_reg.op)
                    OP_LOAD:
                    begin
                        mem_we = 1'b1;
                    end
                    OP_FLIP:
                    begin
                        mem_rd_en = 1'b1;
                    end
                    OP_CHECK:
                    begin
                        rd_addr_next = '0;
                        depth_next   = '0;
                        fail_next    = 1'b0;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            BK_FLIP:
            begin
                // Swap a bracket in place; other symbols stay
                rd_addr_next = '0;
                depth_next   = '0;
                fail_next    = 1'b0;
                if (rd_data_reg == SYM_OPEN)
                begin
                    mem_we      = 1'b1;
                    mem_wr_data = SYM_CLOSE;
                end
                else if (rd_data_reg == SYM_CLOSE)
                begin
                    mem_we      = 1'b1;
                    mem_wr_data = SYM_OPEN;
                end
            end
            BK_WALK:
            begin
                // Fold in the symbol read last cycle
                if (pend_reg)
                begin
                    if (rd_data_reg == SYM_OPEN)
                    begin
                        depth_next = depth_reg + LEN_W'(1);
                    end
                    else if (rd_data_reg == SYM_CLOSE)
                    begin
                        if (depth_reg == '0)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            depth_next = depth_reg - LEN_W'(1);
                        end
                    end
                end
                // Issue the next read
                if (rd_addr_reg < used_len)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = rd_addr_reg[ADDR_W-1:0];
                    rd_addr_next = rd_addr_reg + LEN_W'(1);
                    pend_next    = 1'b1;
                end
                // Report once every symbol is folded in
                if (walk_end)
                begin
                    done_next                = 1'b1;
                    result_next.balanced     = !fail_reg && (depth_reg == '0);
                    result_next.bad_position = cmd_reg.bad;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            rd_addr_reg <= '0;
            pend_reg    <= 1'b0;
            depth_reg   <= '0;
            fail_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= rd_addr_next;
            pend_reg    <= pend_next;
            depth_reg   <= depth_next;
            fail_reg    <= fail_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    // Symbol memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sym_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= sym_mem[mem_rd_addr];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/bracket_balance_checker.sv =====
// Top level of the bracket balance checker: front end, command queue, back end.
// Depends on bbc_pkg, bbc_front, bbc_cmd_queue and bbc_back.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------------
//  input     | start & !busy            | item   (action, position, symbol_code)
//  result    | done, one-cycle strobe   | result (balanced, bad_position)
//  config    | cfg_wr_en                | cfg_wr_data (string_length)
//
// A load writes its symbol in BK_EXEC. A check goes from BK_EXEC to BK_WALK; a
// flip reads in BK_EXEC, writes back in BK_FLIP, then walks. Each walk covers the
// saturated string length via the memory's single read port, one symbol a cycle.
// The front accepts a beat whenever the two-entry command queue has room, so it
// keeps taking beats while the back end walks. Reset clears the length, queue
// and sequencer; the symbol memory holds no reset value.
// The receiver cannot stall: each result beat stands for one cycle only.
module bracket_balance_checker #(
    parameter int MAX_LEN = bbc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bbc_pkg::LENGTH_WIDTH-1:0] cfg_wr_data,
    input  logic                             start,
    input  bbc_pkg::in_t                     item,
    output logic                             busy,
    output logic                             done,
    output bbc_pkg::out_t                    result
);
    import bbc_pkg::*;

    localparam int LEN_W = ($clog2(MAX_LEN + 1) > LENGTH_WIDTH) ? $clog2(MAX_LEN + 1)
                           : LENGTH_WIDTH;

    logic             q_full;
    logic             push;
    cmd_t             push_cmd;
    logic             q_valid;
    cmd_t             q_cmd;
    logic             q_pop;
    logic [LEN_W-1:0] used_len;

    // Accept and classify beats
    bbc_front #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .item        (item),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd),
        .used_len    (used_len)
    );

    // Buffer commands between the two sides
    bbc_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .cmd      (q_cmd)
    );

    // Execute commands and walk the string
    bbc_back #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .used_len (used_len),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .done     (done),
        .result   (result)
    );

    assign busy = q_full;

endmodule
